// ===== rtl/svg_pkg.sv =====
// Shared types, field widths, opcodes and constants of the state vector gate unit.
// Depends on nothing; every other file but svg_ram and svg_checker imports it.
`timescale 1ns / 1ps

package svg_pkg;

  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned DATA_W   = 18;
  localparam int unsigned QUBIT_W  = 4;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned CFG_W    = 4;

  localparam int unsigned MAX_QUBITS_DEF = 10;
  localparam int unsigned AMP_WIDTH_DEF  = 18;
  localparam logic [CFG_W-1:0] QUBIT_COUNT_RST = 4'd10;

  localparam int unsigned COEF_W = 18;
  localparam logic signed [COEF_W-1:0] COEF_ONE    = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_HALF   = 18'sd32768;
  localparam logic signed [COEF_W-1:0] COEF_RSQRT2 = 18'sd46341;

  localparam int unsigned CORDIC_W = 34;
  localparam logic [3:0] CORDIC_LAST = 4'd15;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 4'd0,
    OP_READ  = 4'd1,
    OP_X     = 4'd2,
    OP_RZ    = 4'd3,
    OP_RX    = 4'd4,
    OP_SX    = 4'd5,
    OP_CZ    = 4'd6,
    OP_RZZ   = 4'd7,
    OP_ECR   = 4'd8
  } op_e;

  typedef struct packed {
    logic       capture;
    logic       wr_single;
    logic       rd_single;
    logic       cordic_start;
    logic       grp_clr;
    logic       grp_inc;
    logic       rd_en;
    logic       calc_en;
    logic [1:0] member;
    logic       out_load;
  } svg_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_read;
    logic bad;
    logic needs_cordic;
    logic two_q;
    logic cordic_done;
    logic last_grp;
    logic pipe_busy;
  } svg_stat_t;

  function automatic logic signed [CORDIC_W-1:0] atan_at(logic [3:0] step);
    case (step)
      4'd0:    return 34'sd536870912;
      4'd1:    return 34'sd316933406;
      4'd2:    return 34'sd167458907;
      4'd3:    return 34'sd85004756;
      4'd4:    return 34'sd42667331;
      4'd5:    return 34'sd21354465;
      4'd6:    return 34'sd10679838;
      4'd7:    return 34'sd5340245;
      4'd8:    return 34'sd2670163;
      4'd9:    return 34'sd1335087;
      4'd10:   return 34'sd667544;
      4'd11:   return 34'sd333772;
      4'd12:   return 34'sd166886;
      4'd13:   return 34'sd83443;
      4'd14:   return 34'sd41722;
      4'd15:   return 34'sd20861;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/svg_in_if.sv =====
// Command channel: valid/ready handshake with the command fields.
// Depends on svg_pkg.
`timescale 1ns / 1ps

interface svg_in_if;
  import svg_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [INDEX_W-1:0]        amp_index;
  logic signed [DATA_W-1:0]  write_real;
  logic signed [DATA_W-1:0]  write_imag;
  logic [QUBIT_W-1:0]        first_qubit;
  logic [QUBIT_W-1:0]        second_qubit;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, opcode, amp_index, write_real, write_imag, first_qubit,
                  second_qubit, angle, input ready);
  modport sink   (input valid, opcode, amp_index, write_real, write_imag, first_qubit,
                  second_qubit, angle, output ready);
endinterface

// ===== rtl/svg_out_if.sv =====
// Result channel: valid/ready handshake with status and read-back data.
// Depends on svg_pkg.
`timescale 1ns / 1ps

interface svg_out_if;
  import svg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [DATA_W-1:0] read_real;
  logic signed [DATA_W-1:0] read_imag;

  modport source (output valid, status, read_real, read_imag, input ready);
  modport sink   (input valid, status, read_real, read_imag, output ready);
endinterface

// ===== rtl/svg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module svg_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/svg_cordic.sv =====
// Iterative CORDIC, one rotation step per cycle: cos and sin of the half angle.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_cordic (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [svg_pkg::ANGLE_W-1:0]        angle_i,
  output logic                                      done_o,
  output logic signed [svg_pkg::COEF_W-1:0]         cos_o,
  output logic signed [svg_pkg::COEF_W-1:0]         sin_o
);
  import svg_pkg::*;

  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [CORDIC_W-1:0] dx, dy, xr, yr;
  logic [3:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    if (start_i) begin
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = CORDIC_W'(angle_i) <<< 15;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_at(step_q);
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_at(step_q);
      end
      if (step_q == CORDIC_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    xr = (x_q + CORDIC_W'(8192)) >>> 14;
    yr = (y_q + CORDIC_W'(8192)) >>> 14;
    if (xr > CORDIC_W'(65536))       cos_o = COEF_ONE;
    else if (xr < -CORDIC_W'(65536)) cos_o = -COEF_ONE;
    else                             cos_o = xr[COEF_W-1:0];
    if (yr > CORDIC_W'(65536))       sin_o = COEF_ONE;
    else if (yr < -CORDIC_W'(65536)) sin_o = -COEF_ONE;
    else                             sin_o = yr[COEF_W-1:0];
  end

  assign done_o = done_q;

endmodule

// ===== rtl/svg_datapath.sv =====
// Datapath: command latch, qubit count register, amplitude RAM, operand registers,
// two-stage multiply/round pipeline and result register. Depends on svg_pkg,
// svg_ram and svg_cordic.
`timescale 1ns / 1ps

module svg_datapath #(
  parameter int unsigned MAX_QUBITS = svg_pkg::MAX_QUBITS_DEF,
  parameter int unsigned AMP_WIDTH  = svg_pkg::AMP_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svg_pkg::svg_cmd_t                   cmd_i,
  output svg_pkg::svg_stat_t                  stat_o,
  input  logic [svg_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [svg_pkg::INDEX_W-1:0]         amp_index_i,
  input  logic signed [svg_pkg::DATA_W-1:0]   write_real_i,
  input  logic signed [svg_pkg::DATA_W-1:0]   write_imag_i,
  input  logic [svg_pkg::QUBIT_W-1:0]         first_qubit_i,
  input  logic [svg_pkg::QUBIT_W-1:0]         second_qubit_i,
  input  logic signed [svg_pkg::ANGLE_W-1:0]  angle_i,
  input  logic                                cfg_we_i,
  input  logic [svg_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                status_o,
  output logic signed [svg_pkg::DATA_W-1:0]   read_real_o,
  output logic signed [svg_pkg::DATA_W-1:0]   read_imag_o
);
  import svg_pkg::*;

  localparam int unsigned AW    = MAX_QUBITS;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned IW    = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int unsigned XW    = AMP_WIDTH + 2;
  localparam int unsigned PW    = COEF_W + XW;
  localparam int unsigned SW    = PW + 1;
  localparam logic signed [SW-1:0] AMP_HI = SW'((longint'(1) <<< (AMP_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] AMP_LO = SW'(-(longint'(1) <<< (AMP_WIDTH - 1)));
  localparam logic signed [SW-1:0] OUT_HI = SW'((longint'(1) <<< (DATA_W - 1)) - 1);
  localparam logic signed [SW-1:0] OUT_LO = SW'(-(longint'(1) <<< (DATA_W - 1)));

  function automatic logic signed [AMP_WIDTH-1:0] sat_amp(logic signed [SW-1:0] v);
    if (v > AMP_HI)      return AMP_HI[AMP_WIDTH-1:0];
    else if (v < AMP_LO) return AMP_LO[AMP_WIDTH-1:0];
    else                 return v[AMP_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(logic signed [SW-1:0] v);
    if (v > OUT_HI)      return OUT_HI[DATA_W-1:0];
    else if (v < OUT_LO) return OUT_LO[DATA_W-1:0];
    else                 return v[DATA_W-1:0];
  endfunction

  function automatic logic [AW-1:0] ins_zero(logic [AW-1:0] v, logic [QUBIT_W-1:0] q);
    logic [AW-1:0] low_mask;
    low_mask = (AW'(1) << q) - AW'(1);
    return ((v & ~low_mask) << 1) | (v & low_mask);
  endfunction

  // command latch and configuration
  logic [CFG_W-1:0]          qc_q;
  logic [OPCODE_W-1:0]       op_q;
  logic [INDEX_W-1:0]        idx_q;
  logic signed [DATA_W-1:0]  wre_q, wim_q;
  logic [QUBIT_W-1:0]        q1_q, q2_q;
  logic signed [ANGLE_W-1:0] ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= QUBIT_COUNT_RST;
    end else if (cfg_we_i) begin
      qc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      idx_q <= amp_index_i;
      wre_q <= write_real_i;
      wim_q <= write_imag_i;
      q1_q  <= first_qubit_i;
      q2_q  <= second_qubit_i;
      ang_q <= angle_i;
    end
  end

  // decode
  logic [7:0] n8, q1_8, q2_8, shamt;
  logic is_one_q, is_two_q, bad;

  always_comb begin
    if (qc_q == '0)                       n8 = 8'd1;
    else if (8'(qc_q) > 8'(MAX_QUBITS))   n8 = 8'(MAX_QUBITS);
    else                                  n8 = 8'(qc_q);
    q1_8     = 8'(q1_q);
    q2_8     = 8'(q2_q);
    is_one_q = (op_q == OP_X) || (op_q == OP_RZ) || (op_q == OP_RX) || (op_q == OP_SX);
    is_two_q = (op_q == OP_CZ) || (op_q == OP_RZZ) || (op_q == OP_ECR);
    bad      = (op_q > OP_ECR)
            || (is_one_q && (q1_8 >= n8))
            || (is_two_q && ((q1_8 >= n8) || (q2_8 >= n8) || (q1_q == q2_q)));
    shamt    = n8 - (is_two_q ? 8'd2 : 8'd1);
  end

  // group walk
  logic [AW-1:0] grp_q, base, bit1, bit2, grp_lim, maddr, amp_addr;
  logic [AW:0]   span;
  logic [QUBIT_W-1:0] q_lo, q_hi;
  logic [IW-1:0] idx_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp_clr) begin
      grp_q <= '0;
    end else if (cmd_i.grp_inc) begin
      grp_q <= grp_q + AW'(1);
    end
  end

  always_comb begin
    q_lo     = (q1_q < q2_q) ? q1_q : q2_q;
    q_hi     = (q1_q < q2_q) ? q2_q : q1_q;
    base     = is_two_q ? ins_zero(ins_zero(grp_q, q_lo), q_hi) : ins_zero(grp_q, q1_q);
    bit1     = AW'(1) << q1_q;
    bit2     = AW'(1) << q2_q;
    maddr    = base | (cmd_i.member[0] ? bit1 : '0) | (cmd_i.member[1] ? bit2 : '0);
    span     = (AW + 1)'(1) << shamt;
    grp_lim  = span[AW-1:0] - AW'(1);
    idx_ext  = IW'(idx_q);
    amp_addr = idx_ext[AW-1:0];
  end

  // CORDIC
  logic signed [COEF_W-1:0] cos_v, sin_v;
  logic cordic_done;

  svg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .angle_i (ang_q),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // memory
  logic                     s2_v_q;
  logic [AW-1:0]            s1_addr_q, s2_addr_q;
  logic signed [AMP_WIDTH-1:0] s2_re_q, s2_im_q;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [2*AMP_WIDTH-1:0]   ram_wdata, ram_rdata;
  logic signed [AMP_WIDTH-1:0] rd_re, rd_im;

  always_comb begin
    ram_we    = s2_v_q | cmd_i.wr_single;
    ram_waddr = s2_v_q ? s2_addr_q : amp_addr;
    ram_wdata = s2_v_q ? {s2_re_q, s2_im_q}
                       : {sat_amp(SW'(wre_q)), sat_amp(SW'(wim_q))};
    ram_re    = cmd_i.rd_en | cmd_i.rd_single;
    ram_raddr = cmd_i.rd_en ? maddr : amp_addr;
    rd_re     = ram_rdata[2*AMP_WIDTH-1:AMP_WIDTH];
    rd_im     = ram_rdata[AMP_WIDTH-1:0];
  end

  svg_ram #(
    .WIDTH (2 * AMP_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // operand capture, in the cycle after the read
  logic       cap_v_q;
  logic [1:0] cap_m_q;
  logic signed [AMP_WIDTH-1:0] ore_q [4];
  logic signed [AMP_WIDTH-1:0] oim_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
    end else begin
      cap_v_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_m_q <= cmd_i.member;
    if (cap_v_q) begin
      ore_q[cap_m_q] <= rd_re;
      oim_q[cap_m_q] <= rd_im;
    end
  end

  // term selection
  logic signed [XW-1:0]     ar [4];
  logic signed [XW-1:0]     ai [4];
  logic signed [COEF_W-1:0] ca_re, cb_re, ca_im, cb_im;
  logic signed [XW-1:0]     xa_re, xb_re, xa_im, xb_im;
  logic [1:0]               mb;
  logic                     odd;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ar[k] = XW'(ore_q[k]);
      ai[k] = XW'(oim_q[k]);
    end
  end

  always_comb begin
    mb    = cmd_i.member;
    odd   = mb[0] ^ mb[1];
    ca_re = '0;
    cb_re = '0;
    ca_im = '0;
    cb_im = '0;
    xa_re = '0;
    xb_re = '0;
    xa_im = '0;
    xb_im = '0;
    case (op_e'(op_q))
      OP_X: begin
        ca_re = COEF_ONE;
        ca_im = COEF_ONE;
        xa_re = mb[0] ? ar[0] : ar[1];
        xa_im = mb[0] ? ai[0] : ai[1];
      end
      OP_RZ: begin
        if (!mb[0]) begin
          ca_re = cos_v;  xa_re = ar[0]; cb_re = sin_v;  xb_re = ai[0];
          ca_im = cos_v;  xa_im = ai[0]; cb_im = -sin_v; xb_im = ar[0];
        end else begin
          ca_re = cos_v;  xa_re = ar[1]; cb_re = -sin_v; xb_re = ai[1];
          ca_im = sin_v;  xa_im = ar[1]; cb_im = cos_v;  xb_im = ai[1];
        end
      end
      OP_RX: begin
        if (!mb[0]) begin
          ca_re = cos_v;  xa_re = ar[0]; cb_re = sin_v;  xb_re = ai[1];
          ca_im = cos_v;  xa_im = ai[0]; cb_im = -sin_v; xb_im = ar[1];
        end else begin
          ca_re = sin_v;  xa_re = ai[0]; cb_re = cos_v;  xb_re = ar[1];
          ca_im = cos_v;  xa_im = ai[1]; cb_im = -sin_v; xb_im = ar[0];
        end
      end
      OP_SX: begin
        ca_re = COEF_HALF;
        ca_im = COEF_HALF;
        if (!mb[0]) begin
          xa_re = ar[0] - ai[0] + ar[1] + ai[1];
          xa_im = ar[0] + ai[0] - ar[1] + ai[1];
        end else begin
          xa_re = ar[0] + ai[0] + ar[1] - ai[1];
          xa_im = ai[0] - ar[0] + ar[1] + ai[1];
        end
      end
      OP_CZ: begin
        ca_re = (mb == 2'd3) ? -COEF_ONE : COEF_ONE;
        ca_im = ca_re;
        xa_re = ar[mb];
        xa_im = ai[mb];
      end
      OP_RZZ: begin
        ca_re = cos_v;
        xa_re = ar[mb];
        cb_re = odd ? -sin_v : sin_v;
        xb_re = ai[mb];
        ca_im = cos_v;
        xa_im = ai[mb];
        cb_im = odd ? sin_v : -sin_v;
        xb_im = ar[mb];
      end
      OP_ECR: begin
        ca_re = COEF_RSQRT2;
        ca_im = COEF_RSQRT2;
        case (mb)
          2'd0: begin
            xa_re = ar[1] - ai[3];
            xa_im = ai[1] + ar[3];
          end
          2'd1: begin
            xa_re = ar[0] + ai[2];
            xa_im = ai[0] - ar[2];
          end
          2'd2: begin
            xa_re = ar[3] - ai[1];
            xa_im = ai[3] + ar[1];
          end
          default: begin
            xa_re = ar[2] + ai[0];
            xa_im = ai[2] - ar[0];
          end
        endcase
      end
      default: begin
        ca_re = '0;
      end
    endcase
  end

  // multiply stage, then sum, round and saturate stage
  logic                 s1_v_q;
  logic signed [PW-1:0] pa_re_q, pb_re_q, pa_im_q, pb_im_q;
  logic signed [SW-1:0] sum_re, sum_im, rnd_re, rnd_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.calc_en;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_re_q   <= PW'(ca_re) * PW'(xa_re);
    pb_re_q   <= PW'(cb_re) * PW'(xb_re);
    pa_im_q   <= PW'(ca_im) * PW'(xa_im);
    pb_im_q   <= PW'(cb_im) * PW'(xb_im);
    s1_addr_q <= maddr;
    s2_addr_q <= s1_addr_q;
    s2_re_q   <= sat_amp(rnd_re);
    s2_im_q   <= sat_amp(rnd_im);
  end

  always_comb begin
    sum_re = SW'(pa_re_q) + SW'(pb_re_q);
    sum_im = SW'(pa_im_q) + SW'(pb_im_q);
    rnd_re = (sum_re + SW'(32768)) >>> 16;
    rnd_im = (sum_im + SW'(32768)) >>> 16;
  end

  // result register
  logic                     status_q;
  logic signed [DATA_W-1:0] out_re_q, out_im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= bad;
      out_re_q <= (op_q == OP_READ) ? sat_out(SW'(rd_re)) : '0;
      out_im_q <= (op_q == OP_READ) ? sat_out(SW'(rd_im)) : '0;
    end
  end

  assign status_o    = status_q;
  assign read_real_o = out_re_q;
  assign read_imag_o = out_im_q;

  always_comb begin
    stat_o.is_write     = (op_q == OP_WRITE);
    stat_o.is_read      = (op_q == OP_READ);
    stat_o.bad          = bad;
    stat_o.needs_cordic = (op_q == OP_RZ) || (op_q == OP_RX) || (op_q == OP_RZZ);
    stat_o.two_q        = is_two_q;
    stat_o.cordic_done  = cordic_done;
    stat_o.last_grp     = (grp_q == grp_lim);
    stat_o.pipe_busy    = s1_v_q | s2_v_q;
  end

endmodule

// ===== rtl/svg_ctrl.sv =====
// Controller: sequences commands, group reads, compute slots and the result beat.
// Depends on svg_pkg.
`timescale 1ns / 1ps

module svg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  svg_pkg::svg_stat_t stat_i,
  output svg_pkg::svg_cmd_t  cmd_o
);
  import svg_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_READW  = 9'b000000100,
    ST_CORDIC = 9'b000001000,
    ST_RD     = 9'b000010000,
    ST_RWAIT  = 9'b000100000,
    ST_CALC   = 9'b001000000,
    ST_DRAIN  = 9'b010000000,
    ST_RESP   = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] mem_q, mem_d;
  logic       valid_q, valid_d;
  logic       last_mem;

  always_comb begin
    state_d  = state_q;
    mem_d    = mem_q;
    valid_d  = valid_q;
    cmd_o    = '0;
    last_mem = (mem_q == (stat_i.two_q ? 2'd3 : 2'd1));
    cmd_o.member = mem_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.grp_clr = 1'b1;
        mem_d         = '0;
        if (stat_i.is_write) begin
          cmd_o.wr_single = 1'b1;
          state_d         = ST_RESP;
        end else if (stat_i.is_read) begin
          cmd_o.rd_single = 1'b1;
          state_d         = ST_READW;
        end else if (stat_i.bad) begin
          state_d = ST_RESP;
        end else if (stat_i.needs_cordic) begin
          cmd_o.cordic_start = 1'b1;
          state_d            = ST_CORDIC;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_READW: begin
        state_d = ST_RESP;
      end
      ST_CORDIC: begin
        if (stat_i.cordic_done) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        if (last_mem) begin
          mem_d   = '0;
          state_d = ST_RWAIT;
        end else begin
          mem_d = mem_q + 2'd1;
        end
      end
      ST_RWAIT: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        if (last_mem) begin
          mem_d = '0;
          if (stat_i.last_grp) begin
            state_d = ST_DRAIN;
          end else begin
            cmd_o.grp_inc = 1'b1;
            state_d       = ST_RD;
          end
        end else begin
          mem_d = mem_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          valid_d        = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mem_q   <= mem_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

// ===== rtl/state_vector_gate_unit.sv =====
// Top level of the state vector gate unit: controller, datapath and channel wiring.
// Depends on svg_pkg, svg_in_if, svg_out_if, svg_ctrl and svg_datapath.
//
//   Channel    Dir  Handshake            Beat
//   in_ch_i    in   valid/ready          one command (write, read or gate)
//   out_ch_o   out  valid/ready          one result: status, read_real, read_imag
//   cfg        in   cfg_we_i             qubit_count, taken on the enable edge
//
// RZ, RX and RZZ first run the CORDIC. Each amplitude is read once through the single
// read port of the amplitude RAM, then rewritten through a 2-stage pipe.
// Reset clears control state and sets qubit_count to 10; amplitudes are undefined until written.
// A new command is taken while a result beat still waits on out_ch_o.
`timescale 1ns / 1ps

module state_vector_gate_unit #(
  parameter int unsigned MAX_QUBITS = svg_pkg::MAX_QUBITS_DEF,
  parameter int unsigned AMP_WIDTH  = svg_pkg::AMP_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  svg_in_if.sink                     in_ch_i,
  svg_out_if.source                  out_ch_o,
  input  logic                       cfg_we_i,
  input  logic [svg_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import svg_pkg::*;

  svg_cmd_t  cmd;
  svg_stat_t stat;

  svg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  svg_datapath #(
    .MAX_QUBITS (MAX_QUBITS),
    .AMP_WIDTH  (AMP_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (in_ch_i.opcode),
    .amp_index_i    (in_ch_i.amp_index),
    .write_real_i   (in_ch_i.write_real),
    .write_imag_i   (in_ch_i.write_imag),
    .first_qubit_i  (in_ch_i.first_qubit),
    .second_qubit_i (in_ch_i.second_qubit),
    .angle_i        (in_ch_i.angle),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_o       (out_ch_o.status),
    .read_real_o    (out_ch_o.read_real),
    .read_imag_o    (out_ch_o.read_imag)
  );

endmodule

// ===== rtl/svg_checker.sv =====
// Port-level checks of the state vector gate unit and the bind that attaches them.
// Depends on state_vector_gate_unit.
`timescale 1ns / 1ps

module svg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_status_i,
  input logic [17:0] out_real_i,
  input logic [17:0] out_imag_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> (out_real_i == 18'd0) && (out_imag_i == 18'd0))
    else $error("error result carries read data");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while previous one still in work");

  a_resp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result beat appeared without a command in work");

endmodule

bind state_vector_gate_unit svg_checker u_svg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch_i.valid),
  .in_ready_i   (in_ch_i.ready),
  .out_valid_i  (out_ch_o.valid),
  .out_ready_i  (out_ch_o.ready),
  .out_status_i (out_ch_o.status),
  .out_real_i   (out_ch_o.read_real),
  .out_imag_i   (out_ch_o.read_imag)
);

// ===== tb/sv/tb_state_vector_gate_unit.sv =====
// Self-checking testbench for state_vector_gate_unit: drives command beats, predicts every
// result beat from an internal amplitude store model and compares on the result channel.
// Depends on svg_pkg, svg_in_if, svg_out_if and the state_vector_gate_unit RTL.
`timescale 1ns / 1ps

module tb_state_vector_gate_unit;
  import svg_pkg::*;

  localparam int unsigned DEPTH = 1 << MAX_QUBITS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ATAN_Q31 [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0] amp_index;
    logic signed [DATA_W-1:0] wr_re;
    logic signed [DATA_W-1:0] wr_im;
    logic [QUBIT_W-1:0] q1;
    logic [QUBIT_W-1:0] q2;
    logic signed [ANGLE_W-1:0] angle;
  } gate_cmd_t;

  typedef struct {
    logic status;
    logic signed [DATA_W-1:0] rd_re;
    logic signed [DATA_W-1:0] rd_im;
  } gate_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  svg_in_if  cmd_ch ();
  svg_out_if res_ch ();

  state_vector_gate_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (cmd_ch),
    .out_ch_o   (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  longint    amp_re [DEPTH];
  longint    amp_im [DEPTH];
  bit        written [DEPTH];
  logic [CFG_W-1:0] qubit_reg;
  gate_res_t results_due [$];
  int        mismatches;
  longint    cycles;
  bit        quiet;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint sat_amp(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint round_amp(longint acc);
    return sat_amp((acc + 32768) >>> 16);
  endfunction

  function automatic int eff_qubits(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_QUBITS_DEF) return MAX_QUBITS_DEF;
    return int'(v);
  endfunction

  task automatic half_angle_trig(input longint theta, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = theta * 32768;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q31[k];
      end else begin
        x += dx; y -= dy; z += ATAN_Q31[k];
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    c = x > 65536 ? 65536 : (x < -65536 ? -65536 : x);
    s = y > 65536 ? 65536 : (y < -65536 ? -65536 : y);
  endtask

  task automatic apply_phase(int k, bit odd, longint c, longint s);
    longint r, m;
    r = amp_re[k];
    m = amp_im[k];
    if (odd) begin
      amp_re[k] = round_amp(c * r - s * m); amp_im[k] = round_amp(s * r + c * m);
    end else begin
      amp_re[k] = round_amp(c * r + s * m); amp_im[k] = round_amp(c * m - s * r);
    end
  endtask

  task automatic apply_command(gate_cmd_t cmd);
    gate_res_t res;
    int n, dim, b1, b2, j, k1, k2, k3;
    longint c, s, r0, i0, r1, i1, r2, i2, r3, i3;
    res = '{1'b0, '0, '0};
    n = eff_qubits(qubit_reg);
    dim = 1 << n;
    c = 65536;
    s = 0;
    if (cmd.opcode inside {OP_RZ, OP_RX, OP_RZZ}) half_angle_trig(longint'(cmd.angle), c, s);
    b1 = 1 << cmd.q1;
    b2 = 1 << cmd.q2;
    if (cmd.opcode == OP_WRITE) begin
      amp_re[cmd.amp_index] = longint'(cmd.wr_re);
      amp_im[cmd.amp_index] = longint'(cmd.wr_im);
      written[cmd.amp_index] = 1'b1;
    end else if (cmd.opcode == OP_READ) begin
      res.rd_re = DATA_W'(amp_re[cmd.amp_index]);
      res.rd_im = DATA_W'(amp_im[cmd.amp_index]);
    end else if (cmd.opcode >= OP_X && cmd.opcode <= OP_SX) begin
      if (cmd.q1 >= n) res.status = 1'b1;
      else begin
        for (int i = 0; i < dim; i++) begin
          if ((i & b1) != 0) continue;
          j = i | b1;
          r0 = amp_re[i]; i0 = amp_im[i]; r1 = amp_re[j]; i1 = amp_im[j];
          case (cmd.opcode)
            OP_X: begin
              amp_re[i] = r1; amp_im[i] = i1; amp_re[j] = r0; amp_im[j] = i0;
            end
            OP_RZ: begin
              amp_re[i] = round_amp(c * r0 + s * i0); amp_im[i] = round_amp(c * i0 - s * r0);
              amp_re[j] = round_amp(c * r1 - s * i1); amp_im[j] = round_amp(s * r1 + c * i1);
            end
            OP_RX: begin
              amp_re[i] = round_amp(c * r0 + s * i1); amp_im[i] = round_amp(c * i0 - s * r1);
              amp_re[j] = round_amp(s * i0 + c * r1); amp_im[j] = round_amp(c * i1 - s * r0);
            end
            default: begin
              amp_re[i] = round_amp(32768 * (r0 - i0 + r1 + i1));
              amp_im[i] = round_amp(32768 * (r0 + i0 - r1 + i1));
              amp_re[j] = round_amp(32768 * (r0 + i0 + r1 - i1));
              amp_im[j] = round_amp(32768 * (i0 - r0 + r1 + i1));
            end
          endcase
        end
      end
    end else if (cmd.opcode >= OP_CZ && cmd.opcode <= OP_ECR) begin
      if (cmd.q1 >= n || cmd.q2 >= n || cmd.q1 == cmd.q2) res.status = 1'b1;
      else begin
        for (int i = 0; i < dim; i++) begin
          if ((i & (b1 | b2)) != 0) continue;
          k1 = i | b1; k2 = i | b2; k3 = i | b1 | b2;
          if (cmd.opcode == OP_CZ) begin
            amp_re[k3] = sat_amp(-amp_re[k3]);
            amp_im[k3] = sat_amp(-amp_im[k3]);
          end else if (cmd.opcode == OP_RZZ) begin
            apply_phase(i, 0, c, s); apply_phase(k1, 1, c, s);
            apply_phase(k2, 1, c, s); apply_phase(k3, 0, c, s);
          end else begin
            r0 = amp_re[i];  i0 = amp_im[i];  r1 = amp_re[k1]; i1 = amp_im[k1];
            r2 = amp_re[k2]; i2 = amp_im[k2]; r3 = amp_re[k3]; i3 = amp_im[k3];
            amp_re[i]  = round_amp(46341 * (r1 - i3)); amp_im[i]  = round_amp(46341 * (i1 + r3));
            amp_re[k1] = round_amp(46341 * (r0 + i2)); amp_im[k1] = round_amp(46341 * (i0 - r2));
            amp_re[k2] = round_amp(46341 * (r3 - i1)); amp_im[k2] = round_amp(46341 * (i3 + r1));
            amp_re[k3] = round_amp(46341 * (r2 + i0)); amp_im[k3] = round_amp(46341 * (i2 - r0));
          end
        end
      end
    end else begin
      res.status = 1'b1;
    end
    results_due.push_back(res);
  endtask

  // Call at a rising edge; returns at the edge where the beat is taken.
  task automatic send_cmd(gate_cmd_t cmd);
    if (!quiet && $urandom_range(99) < 8) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.opcode       <= cmd.opcode;
    cmd_ch.amp_index    <= cmd.amp_index;
    cmd_ch.write_real   <= cmd.wr_re;
    cmd_ch.write_imag   <= cmd.wr_im;
    cmd_ch.first_qubit  <= cmd.q1;
    cmd_ch.second_qubit <= cmd.q2;
    cmd_ch.angle        <= cmd.angle;
    do @(posedge clk_i); while (!cmd_ch.ready);
    apply_command(cmd);
  endtask

  task automatic drain;
    cmd_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_qubits(logic [CFG_W-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    qubit_reg  = v;
  endtask

  function automatic gate_cmd_t make_cmd(op_e op, int idx, longint re, longint im,
                                         int q1, int q2, longint ang);
    gate_cmd_t cmd;
    cmd.opcode = op;
    cmd.amp_index = INDEX_W'(idx);
    cmd.wr_re = DATA_W'(re);
    cmd.wr_im = DATA_W'(im);
    cmd.q1 = QUBIT_W'(q1);
    cmd.q2 = QUBIT_W'(q2);
    cmd.angle = ANGLE_W'(ang);
    return cmd;
  endfunction

  function automatic longint rand_amp();
    case ($urandom_range(9))
      0: return 131071;
      1: return -131072;
      2, 3: return longint'($urandom_range(131071)) - 65536;
      default: return longint'($urandom_range(262143)) - 131072;
    endcase
  endfunction

  function automatic longint rand_angle();
    case ($urandom_range(9))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return longint'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic fill_store(int n);
    for (int i = 0; i < (1 << n); i++)
      if (!written[i]) send_cmd(make_cmd(OP_WRITE, i, rand_amp(), rand_amp(), 0, 0, 0));
  endtask

  task automatic test_directed_ops;
    set_qubits(4'd3);
    send_cmd(make_cmd(OP_WRITE, 0, 131071, -131072, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 1, -131072, 131071, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 2, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_WRITE, 7, 65536, -1, 0, 0, 0));
    fill_store(3);
    send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_X, 0, 0, 0, 2, 0, 0));
    send_cmd(make_cmd(OP_RZ, 0, 0, 0, 0, 0, 32767));
    send_cmd(make_cmd(OP_RX, 0, 0, 0, 1, 0, -32768));
    send_cmd(make_cmd(OP_SX, 0, 0, 0, 2, 0, 0));
    send_cmd(make_cmd(OP_CZ, 0, 0, 0, 0, 2, 0));
    send_cmd(make_cmd(OP_RZZ, 0, 0, 0, 2, 1, 16384));
    send_cmd(make_cmd(OP_ECR, 0, 0, 0, 1, 0, 0));
    send_cmd(make_cmd(OP_ECR, 0, 0, 0, 0, 1, 0));
    send_cmd(make_cmd(OP_READ, 7, 0, 0, 0, 0, 0));
  endtask

  task automatic test_bad_commands;
    gate_cmd_t cmd;
    send_cmd(make_cmd(OP_X, 0, 0, 0, 3, 0, 0));
    send_cmd(make_cmd(OP_RZ, 0, 0, 0, 15, 0, 100));
    send_cmd(make_cmd(OP_CZ, 0, 0, 0, 1, 1, 0));
    send_cmd(make_cmd(OP_RZZ, 0, 0, 0, 0, 9, 0));
    cmd = make_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0);
    cmd.opcode = 4'd9;
    send_cmd(cmd);
    cmd.opcode = 4'd15;
    send_cmd(cmd);
    send_cmd(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0));
  endtask

  // Large vectors are not filled; gates there use an out-of-range target.
  task automatic run_random_phase(logic [CFG_W-1:0] cfg, int count);
    gate_cmd_t cmd;
    int n, dim, pick, idx;
    bit full;
    set_qubits(cfg);
    n = eff_qubits(cfg);
    dim = 1 << n;
    full = (n <= 7);
    if (full) fill_store(n);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      cmd = make_cmd(OP_WRITE, 0, rand_amp(), rand_amp(), 0, 0, rand_angle());
      if ($urandom_range(9) < 8) begin
        cmd.q1 = QUBIT_W'($urandom_range(n - 1));
        cmd.q2 = QUBIT_W'($urandom_range(n - 1));
        if (n > 1 && cmd.q1 == cmd.q2 && $urandom_range(3) != 0)
          cmd.q2 = QUBIT_W'((int'(cmd.q1) + 1) % n);
      end else begin
        cmd.q1 = QUBIT_W'($urandom_range(15));
        cmd.q2 = QUBIT_W'($urandom_range(15));
      end
      if (pick < 20) begin
        cmd.amp_index = INDEX_W'($urandom_range(9) < 8 ? $urandom_range(dim - 1)
                                                       : $urandom_range(DEPTH - 1));
      end else if (pick < 40) begin
        cmd.opcode = OP_READ;
        idx = $urandom_range(DEPTH - 1);
        if (!written[idx]) idx = full ? $urandom_range(dim - 1) : $urandom_range(7);
        cmd.amp_index = INDEX_W'(idx);
      end else if (pick < 95) begin
        cmd.opcode = OPCODE_W'($urandom_range(OP_ECR, OP_X));
        cmd.amp_index = INDEX_W'($urandom_range(DEPTH - 1));
        if (!full) cmd.q1 = QUBIT_W'($urandom_range(15, n));
      end else begin
        cmd.opcode = OPCODE_W'($urandom_range(15, 9));
        cmd.amp_index = INDEX_W'($urandom_range(DEPTH - 1));
      end
      send_cmd(cmd);
    end
  endtask

  task automatic test_random;
    run_random_phase(4'd1, 50);
    run_random_phase(4'd2, 50);
    quiet = 1'b1;
    run_random_phase(4'd4, 50);
    quiet = 1'b0;
    run_random_phase(4'd0, 50);
    run_random_phase(4'd5, 50);
    run_random_phase(4'd3, 50);
    run_random_phase(4'd7, 50);
    run_random_phase(4'd10, 45);
    run_random_phase(4'd15, 45);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) res_ch.ready <= 1'b0;
    else res_ch.ready <= quiet || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    gate_res_t exp_res;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result beat: status %0d", res_ch.status);
        mismatches++;
      end else begin
        exp_res = results_due.pop_front();
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
          mismatches++;
        end
        if (res_ch.read_real !== exp_res.rd_re) begin
          $error("read_real: expected %0d, got %0d", exp_res.rd_re, res_ch.read_real);
          mismatches++;
        end
        if (res_ch.read_imag !== exp_res.rd_im) begin
          $error("read_imag: expected %0d, got %0d", exp_res.rd_im, res_ch.read_imag);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    qubit_reg = QUBIT_COUNT_RST;
    for (int i = 0; i < DEPTH; i++) begin
      amp_re[i] = 0; amp_im[i] = 0; written[i] = 1'b0;
    end
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    res_ch.ready = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = '0;
    cmd_ch.amp_index = '0;
    cmd_ch.write_real = '0;
    cmd_ch.write_imag = '0;
    cmd_ch.first_qubit = '0;
    cmd_ch.second_qubit = '0;
    cmd_ch.angle = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_bad_commands();
    test_random();
    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (results_due.size() != 0) $error("%0d results never arrived", results_due.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
